// ----- src/rsvg_pkg.sv -----
// ----------------------------------------------------------------------------
// rsvg_pkg
// shared constants, tables and handshake types of the ring sector vertex generator
// ----------------------------------------------------------------------------
package rsvg_pkg;

	localparam int MAX_DIVISIONS_DEF = 62;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int CORDIC_GAIN       = 652032874;
	localparam int TURN_64           = 23040;
	// 33423 * 8192, numerator of the outer scale factor in q4.13
	localparam int F_NUM             = 273801216;

	localparam logic [2:0] REG_OUTER_RADIUS = 3'd0;
	localparam logic [2:0] REG_INNER_RADIUS = 3'd1;
	localparam logic [2:0] REG_START_ANGLE  = 3'd2;
	localparam logic [2:0] REG_END_ANGLE    = 3'd3;
	localparam logic [2:0] REG_DIVISIONS    = 3'd4;
	localparam logic [2:0] REG_CLOCKWISE    = 3'd5;

	typedef struct packed {
		logic        start;
		logic [21:0] rem0;
		logic [31:0] low;
		logic [21:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic        start;
		logic [31:0] bam;
	} cor_req_t;

	typedef struct packed {
		logic               done;
		logic signed [15:0] cos_v;
		logic signed [15:0] sin_v;
	} cor_rsp_t;

	// atan(2^-i) as a 32-bit binary angle
	function automatic logic [29:0] atan_val(input logic [4:0] idx);
		logic [29:0] v;
		unique case (idx)
			5'd0:    v = 30'd536870912;
			5'd1:    v = 30'd316933406;
			5'd2:    v = 30'd167458907;
			5'd3:    v = 30'd85004756;
			5'd4:    v = 30'd42667331;
			5'd5:    v = 30'd21354465;
			5'd6:    v = 30'd10680862;
			5'd7:    v = 30'd5340245;
			5'd8:    v = 30'd2670163;
			5'd9:    v = 30'd1335087;
			5'd10:   v = 30'd667544;
			5'd11:   v = 30'd333772;
			5'd12:   v = 30'd166886;
			5'd13:   v = 30'd83443;
			5'd14:   v = 30'd41722;
			5'd15:   v = 30'd20861;
			5'd16:   v = 30'd10430;
			5'd17:   v = 30'd5215;
			5'd18:   v = 30'd2608;
			5'd19:   v = 30'd1304;
			5'd20:   v = 30'd652;
			5'd21:   v = 30'd326;
			5'd22:   v = 30'd163;
			5'd23:   v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- src/rsvg_if.sv -----
// ----------------------------------------------------------------------------
// rsvg_if
// valid/ready channels of the ring sector vertex generator
// ----------------------------------------------------------------------------
interface rsvg_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] progress_angle;

	modport source(output valid, output progress_angle, input ready);
	modport sink(input valid, input progress_angle, output ready);
endinterface

interface rsvg_out_if;
	logic               valid;
	logic               ready;
	logic signed [18:0] outer_x;
	logic signed [18:0] outer_y;
	logic signed [17:0] outer_u;
	logic signed [17:0] outer_v;
	logic signed [18:0] inner_x;
	logic signed [18:0] inner_y;
	logic signed [17:0] inner_u;
	logic signed [17:0] inner_v;
	logic               last_pair;

	modport source(output valid, output outer_x, output outer_y, output outer_u,
		output outer_v, output inner_x, output inner_y, output inner_u,
		output inner_v, output last_pair, input ready);
	modport sink(input valid, input outer_x, input outer_y, input outer_u,
		input outer_v, input inner_x, input inner_y, input inner_u,
		input inner_v, input last_pair, output ready);
endinterface

// ----- src/ring_sector_vertex_generator.sv -----
// ----------------------------------------------------------------------------
// ring_sector_vertex_generator
// emits the outer/inner vertex pairs of a triangle strip for a ring sector
// ----------------------------------------------------------------------------
// usage
//  - configuration: write cfg_we/cfg_index/cfg_wdata while the block is idle;
//    index 0 outer radius, 1 inner radius, 2 start angle, 3 end angle,
//    4 divisions, 5 clockwise; other indexes are dropped
//  - vin carries one progress angle per item; vin.ready is high only while
//    no request is in work
//  - vout carries one vertex pair per item, n+1 walk pairs and then the
//    pair at the progress angle with last_pair set (n+2 items in all)
//  - setup runs the count divide, the half-step angle divide, the cordic
//    and the scale divide; each pair then uses the serial divider three
//    times and the cordic, which runs one stage per cycle; with an outer
//    radius of zero the two texture divides are skipped
//  - results sit in an output register; a stalled receiver only holds the
//    sequencer before the next pair is loaded, nothing is dropped
//  - the last pair may still wait in the output register while the next
//    request is taken
//  - reset puts the registers at their defaults and the sequencer idle
// ----------------------------------------------------------------------------
module ring_sector_vertex_generator #(
	parameter int MAX_DIVISIONS = rsvg_pkg::MAX_DIVISIONS_DEF,
	parameter int CORDIC_STAGES = rsvg_pkg::CORDIC_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	rsvg_in_if.sink     vin,
	rsvg_out_if.source  vout
);

	// sequencer codes
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_NMUL  = 4'd1;
	localparam logic [3:0] ST_NDIV  = 4'd2;
	localparam logic [3:0] ST_HDIV  = 4'd3;
	localparam logic [3:0] ST_HCOR  = 4'd4;
	localparam logic [3:0] ST_FDIV  = 4'd5;
	localparam logic [3:0] ST_RF    = 4'd6;
	localparam logic [3:0] ST_BASE  = 4'd7;
	localparam logic [3:0] ST_NUMLD = 4'd8;
	localparam logic [3:0] ST_PDIV  = 4'd9;
	localparam logic [3:0] ST_PCOR  = 4'd10;
	localparam logic [3:0] ST_MUL   = 4'd11;
	localparam logic [3:0] ST_TDIV  = 4'd12;
	localparam logic [3:0] ST_OUT   = 4'd13;
	localparam logic [3:0] ST_PMUL  = 4'd14;

	// configuration registers
	logic [10:0]        outer_q, inner_q;
	logic signed [15:0] start_q, end_q;
	logic [5:0]         divs_q;
	logic               cw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_q <= 11'd100;
			inner_q <= 11'd50;
			start_q <= 16'sd0;
			end_q   <= 16'sd23040;
			divs_q  <= 6'd8;
			cw_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rsvg_pkg::REG_OUTER_RADIUS: outer_q <= cfg_wdata[10:0];
				rsvg_pkg::REG_INNER_RADIUS: inner_q <= cfg_wdata[10:0];
				rsvg_pkg::REG_START_ANGLE:  start_q <= cfg_wdata;
				rsvg_pkg::REG_END_ANGLE:    end_q   <= cfg_wdata;
				rsvg_pkg::REG_DIVISIONS:    divs_q  <= cfg_wdata[5:0];
				rsvg_pkg::REG_CLOCKWISE:    cw_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	logic [3:0] state_q;
	logic       launched_q;

	// request setup, taken from the registers when an item is accepted
	logic [5:0]         divc;
	logic signed [16:0] span_c, pc17, st17, en17, numn_s;
	logic signed [15:0] lo_c, hi_c, p_c;
	logic [20:0]        den_c;

	always_comb begin
		if (divs_q == 6'd0)
			divc = 6'd1;
		else if ({26'b0, divs_q} > 32'(MAX_DIVISIONS))
			divc = 6'(MAX_DIVISIONS);
		else
			divc = divs_q;
		st17   = {start_q[15], start_q};
		en17   = {end_q[15], end_q};
		span_c = en17 - st17;
		lo_c   = (start_q < end_q) ? start_q : end_q;
		hi_c   = (start_q < end_q) ? end_q : start_q;
		if (vin.progress_angle < lo_c)
			p_c = lo_c;
		else if (vin.progress_angle > hi_c)
			p_c = hi_c;
		else
			p_c = vin.progress_angle;
		pc17   = {p_c[15], p_c};
		numn_s = cw_q ? (en17 - pc17) : (pc17 - st17);
		den_c  = 21'({15'b0, divc} * 21'(rsvg_pkg::TURN_64));
	end

	// per-request registers
	logic signed [15:0] p_q, base_q;
	logic signed [16:0] span_q, step_q;
	logic [16:0]        numn_q;
	logic [5:0]         divc_q, n_q, i_q;
	logic [20:0]        den_q;
	logic [31:0]        bam_q;
	logic signed [15:0] hc_q, c_q, s_q;
	logic signed [16:0] f_q;
	logic signed [28:0] rf_q;
	logic signed [21:0] num_q;
	logic               last_q;
	logic [2:0]         k_q;
	logic               t_q;
	logic signed [18:0] oxt_q, oyt_q, ixt_q, iyt_q;
	logic signed [17:0] out_q, ovt_q;
	logic signed [27:0] rc_q, rs_q, tc_q, ts_q;
	logic signed [46:0] mp_q;

	// shared multiplier
	logic signed [29:0] ma;
	logic signed [16:0] mb;
	logic               mul_en;

	always_comb begin
		ma     = '0;
		mb     = '0;
		mul_en = 1'b0;
		unique case (state_q)
			ST_NMUL: begin
				ma = $signed({13'b0, numn_q});
				mb = $signed({11'b0, divc_q});
				mul_en = 1'b1;
			end
			ST_RF: begin
				ma = $signed({19'b0, outer_q});
				mb = f_q;
				mul_en = 1'b1;
			end
			ST_BASE: begin
				ma = 30'(base_q);
				mb = $signed({11'b0, divc_q});
				mul_en = 1'b1;
			end
			ST_PMUL: begin
				ma = 30'(p_q);
				mb = $signed({11'b0, divc_q});
				mul_en = 1'b1;
			end
			ST_MUL: begin
				mul_en = (k_q != 3'd6);
				unique case (k_q)
					3'd0: begin ma = 30'(rf_q); mb = 17'(c_q); end
					3'd1: begin ma = 30'(rf_q); mb = 17'(s_q); end
					3'd2: begin ma = 30'(f_q); mb = 17'(c_q); end
					3'd3: begin ma = 30'(f_q); mb = 17'(s_q); end
					3'd4: begin ma = $signed({19'b0, inner_q}); mb = 17'(c_q); end
					3'd5: begin ma = $signed({19'b0, inner_q}); mb = 17'(s_q); end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// rounded product terms
	logic signed [46:0] r24, r14, r11;
	assign r24 = mp_q + 47'sd8388608;
	assign r14 = mp_q + 47'sd8192;
	assign r11 = mp_q + 47'sd1024;

	// divider operands
	rsvg_pkg::div_req_t div_req;
	rsvg_pkg::div_rsp_t div_rsp;
	rsvg_pkg::cor_req_t cor_req;
	rsvg_pkg::cor_rsp_t cor_rsp;

	logic [21:0]        two_den, span_abs, hr, pr;
	logic signed [22:0] pr_sum, pr_wrap, pr_sub;
	logic [16:0]        hc_abs;
	logic signed [16:0] hc_ext;
	logic signed [27:0] t_src;
	logic [27:0]        t_abs;

	always_comb begin
		two_den  = {den_q, 1'b0};
		span_abs = span_q[16] ? 22'(-span_q) : 22'(span_q);
		// half step angle reduced into one turn of 2*den
		if (span_q[16]) begin
			if (span_abs > two_den)
				hr = 22'({two_den, 1'b0} - {1'b0, span_abs});
			else
				hr = two_den - span_abs;
		end else if (span_abs >= two_den)
			hr = span_abs - two_den;
		else
			hr = span_abs;
		// vertex angle reduced into one turn of den, it stays within two turns
		pr_sum  = $signed({2'b0, den_q}) + $signed({num_q[21], num_q});
		pr_wrap = $signed({1'b0, two_den}) + $signed({num_q[21], num_q});
		pr_sub  = $signed({num_q[21], num_q}) - $signed({2'b0, den_q});
		if (num_q[21])
			pr = pr_sum[22] ? pr_wrap[21:0] : pr_sum[21:0];
		else if (num_q[20:0] >= den_q)
			pr = pr_sub[21:0];
		else
			pr = num_q[21:0];
		hc_ext = {hc_q[15], hc_q};
		hc_abs = hc_q[15] ? 17'(-hc_ext) : 17'(hc_ext);
		t_src  = t_q ? rs_q : rc_q;
		t_abs  = t_src[27] ? 28'(-t_src) : 28'(t_src);

		div_req       = '0;
		div_req.start = !launched_q;
		unique case (state_q)
			ST_NDIV: begin
				div_req.low = {10'b0, mp_q[21:0]};
				div_req.den = span_abs;
			end
			ST_HDIV: begin
				div_req.rem0 = hr;
				div_req.low  = {11'b0, den_q};
				div_req.den  = two_den;
			end
			ST_FDIV: begin
				div_req.low = 32'(rsvg_pkg::F_NUM) + {16'b0, hc_abs[16:1]};
				div_req.den = {5'b0, hc_abs};
				div_req.start = !launched_q && (hc_q != 16'sd0);
			end
			ST_PDIV: begin
				div_req.rem0 = pr;
				div_req.low  = {12'b0, den_q[20:1]};
				div_req.den  = {1'b0, den_q};
			end
			ST_TDIV: begin
				div_req.low = {4'b0, t_abs} + {21'b0, outer_q};
				div_req.den = {10'b0, outer_q, 1'b0};
				div_req.start = !launched_q && (outer_q != 11'd0);
			end
			default: div_req.start = 1'b0;
		endcase

		cor_req.start = !launched_q && (state_q == ST_HCOR || state_q == ST_PCOR);
		cor_req.bam   = bam_q;
	end

	rsvg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	rsvg_cordic #(
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cor_req),
		.rsp    (cor_rsp)
	);

	// scale factor from the divider quotient, saturated to magnitude 4
	logic [16:0]        f_mag;
	logic signed [16:0] f_new;
	assign f_mag = (div_rsp.quo > 32'd32768) ? 17'd32768 : div_rsp.quo[16:0];
	assign f_new = hc_q[15] ? -$signed(f_mag) : $signed(f_mag);

	// signed texture quotient
	logic signed [27:0] t_new;
	assign t_new = t_src[27] ? -$signed(div_rsp.quo[27:0]) : $signed(div_rsp.quo[27:0]);

	// output assembly
	logic               out_valid_q;
	logic               load_out;
	logic signed [18:0] ctr;
	logic signed [28:0] iu_sum, iv_sum;

	assign ctr    = $signed({4'b0, outer_q, 4'b0});
	assign iu_sum = 29'sd16384 + 29'(tc_q);
	assign iv_sum = 29'sd16384 - 29'(ts_q);
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || vout.ready);

	function automatic logic signed [17:0] tex_sat(input logic signed [28:0] v);
		if (v > 29'sd131071) return 18'sd131071;
		if (v < -29'sd65536) return -18'sd65536;
		return v[17:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (vout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			vout.outer_x   <= ctr + oxt_q;
			vout.outer_y   <= ctr - oyt_q;
			vout.outer_u   <= 18'sd16384 + out_q;
			vout.outer_v   <= 18'sd16384 - ovt_q;
			vout.inner_x   <= ctr + ixt_q;
			vout.inner_y   <= ctr - iyt_q;
			vout.inner_u   <= tex_sat(iu_sum);
			vout.inner_v   <= tex_sat(iv_sum);
			vout.last_pair <= last_q;
		end
	end

	assign vout.valid = out_valid_q;
	assign vin.ready  = (state_q == ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			launched_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (vin.valid) state_q <= ST_NMUL;
				ST_NMUL: state_q <= (span_q == 17'sd0) ? ST_HDIV : ST_NDIV;
				ST_NDIV, ST_HDIV, ST_PDIV: begin
					if (!launched_q)
						launched_q <= 1'b1;
					else if (div_rsp.done) begin
						launched_q <= 1'b0;
						state_q    <= (state_q == ST_NDIV) ? ST_HDIV :
							(state_q == ST_HDIV) ? ST_HCOR : ST_PCOR;
					end
				end
				ST_HCOR, ST_PCOR: begin
					if (!launched_q)
						launched_q <= 1'b1;
					else if (cor_rsp.done) begin
						launched_q <= 1'b0;
						state_q    <= (state_q == ST_HCOR) ? ST_FDIV : ST_MUL;
					end
				end
				ST_FDIV: begin
					if (hc_q == 16'sd0)
						state_q <= ST_RF;
					else if (!launched_q)
						launched_q <= 1'b1;
					else if (div_rsp.done) begin
						launched_q <= 1'b0;
						state_q    <= ST_RF;
					end
				end
				ST_RF:    state_q <= ST_BASE;
				ST_BASE:  state_q <= ST_NUMLD;
				ST_PMUL:  state_q <= ST_NUMLD;
				ST_NUMLD: state_q <= ST_PDIV;
				ST_MUL:   if (k_q == 3'd6) state_q <= ST_TDIV;
				ST_TDIV: begin
					if (outer_q == 11'd0)
						state_q <= ST_OUT;
					else if (!launched_q)
						launched_q <= 1'b1;
					else if (div_rsp.done) begin
						launched_q <= 1'b0;
						if (t_q) state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						if (last_q)
							state_q <= ST_IDLE;
						else if (i_q == n_q)
							state_q <= ST_PMUL;
						else
							state_q <= ST_PDIV;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (mul_en)
			mp_q <= ma * mb;
		unique case (state_q)
			ST_IDLE: begin
				p_q    <= p_c;
				base_q <= cw_q ? end_q : start_q;
				span_q <= span_c;
				step_q <= cw_q ? -span_c : span_c;
				numn_q <= numn_s[16] ? 17'(-numn_s) : 17'(numn_s);
				divc_q <= divc;
				den_q  <= den_c;
				n_q    <= '0;
			end
			ST_NDIV: begin
				if (launched_q && div_rsp.done)
					n_q <= (div_rsp.quo > {26'b0, divc_q}) ? divc_q : div_rsp.quo[5:0];
			end
			ST_HDIV, ST_PDIV: begin
				if (launched_q && div_rsp.done)
					bam_q <= div_rsp.quo;
			end
			ST_HCOR: begin
				if (launched_q && cor_rsp.done)
					hc_q <= cor_rsp.cos_v;
			end
			ST_PCOR: begin
				if (launched_q && cor_rsp.done) begin
					c_q <= cor_rsp.cos_v;
					s_q <= cor_rsp.sin_v;
					k_q <= '0;
				end
			end
			ST_FDIV: begin
				if (hc_q == 16'sd0)
					f_q <= 17'sd32768;
				else if (launched_q && div_rsp.done)
					f_q <= f_new;
			end
			ST_BASE: begin
				rf_q   <= mp_q[28:0];
				i_q    <= '0;
				last_q <= 1'b0;
			end
			ST_PMUL:  last_q <= 1'b1;
			ST_NUMLD: num_q  <= mp_q[21:0];
			ST_MUL: begin
				k_q <= k_q + 3'd1;
				t_q <= 1'b0;
				unique case (k_q)
					3'd1: oxt_q <= r24[42:24];
					3'd2: oyt_q <= r24[42:24];
					3'd3: out_q <= r14[31:14];
					3'd4: ovt_q <= r14[31:14];
					3'd5: begin ixt_q <= r11[29:11]; rc_q <= mp_q[27:0]; end
					3'd6: begin iyt_q <= r11[29:11]; rs_q <= mp_q[27:0]; end
					default: ;
				endcase
			end
			ST_TDIV: begin
				if (outer_q == 11'd0) begin
					tc_q <= '0;
					ts_q <= '0;
				end else if (launched_q && div_rsp.done) begin
					if (t_q) ts_q <= t_new;
					else     tc_q <= t_new;
					t_q <= 1'b1;
				end
			end
			ST_OUT: begin
				if (load_out && !last_q && i_q != n_q) begin
					i_q   <= i_q + 6'd1;
					num_q <= num_q + 22'(step_q);
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- src/rsvg_div.sv -----
// ----------------------------------------------------------------------------
// rsvg_div
// restoring divider, one quotient bit per cycle, 32 quotient bits
// ----------------------------------------------------------------------------
module rsvg_div (
	input  logic                clk,
	input  logic                arst_n,
	input  rsvg_pkg::div_req_t  req,
	output rsvg_pkg::div_rsp_t  rsp
);

	logic [21:0] rem_q;
	logic [31:0] low_q;
	logic [21:0] den_q;
	logic [31:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [22:0] trial;
	logic        qbit;

	// rem stays below den, so the trial fits one extra bit
	assign trial = {rem_q, low_q[31]};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem0;
			low_q <= req.low;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= qbit ? 22'(trial - {1'b0, den_q}) : trial[21:0];
			low_q <= {low_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// ----- src/rsvg_cordic.sv -----
// ----------------------------------------------------------------------------
// rsvg_cordic
// iterative rotation cordic, one stage per cycle, q1.15 cosine and sine out
// ----------------------------------------------------------------------------
module rsvg_cordic #(
	parameter int CORDIC_STAGES = rsvg_pkg::CORDIC_STAGES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rsvg_pkg::cor_req_t  req,
	output rsvg_pkg::cor_rsp_t  rsp
);

	localparam int CW = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

	logic signed [33:0] x_q, y_q, z_q;
	logic               flip_q;
	logic [CW-1:0]      cnt_q;
	logic               run_q, fin_q, done_q;
	logic signed [15:0] cos_q, sin_q;

	logic signed [33:0] z0, zf, dx, dy, at, xr, yr, xo, yo;
	logic               f0;

	// fold the angle into the right half plane
	always_comb begin
		z0 = $signed({{2{req.bam[31]}}, req.bam});
		f0 = 1'b0;
		zf = z0;
		if (z0 > 34'sd1073741824) begin
			zf = z0 - 34'sd2147483648;
			f0 = 1'b1;
		end else if (z0 < -34'sd1073741824) begin
			zf = z0 + 34'sd2147483648;
			f0 = 1'b1;
		end
	end

	assign dx = y_q >>> cnt_q;
	assign dy = x_q >>> cnt_q;
	assign at = $signed({4'b0, rsvg_pkg::atan_val(5'(cnt_q))});

	function automatic logic signed [15:0] rnd_sat(input logic signed [33:0] v);
		logic signed [33:0] t;
		t = (v + 34'sd16384) >>> 15;
		if (t > 34'sd32767) return 16'sd32767;
		if (t < -34'sd32768) return -16'sd32768;
		return t[15:0];
	endfunction

	assign xo = flip_q ? -x_q : x_q;
	assign yo = flip_q ? -y_q : y_q;
	assign xr = xo;
	assign yr = yo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(CORDIC_STAGES - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q    <= 34'sd652032874;
			y_q    <= '0;
			z_q    <= zf;
			flip_q <= f0;
		end else if (run_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end else if (fin_q) begin
			cos_q <= rnd_sat(xr);
			sin_q <= rnd_sat(yr);
		end
	end

	assign rsp.done  = done_q;
	assign rsp.cos_v = cos_q;
	assign rsp.sin_v = sin_q;

endmodule

// ----- src/rsvg_checker.sv -----
// ----------------------------------------------------------------------------
// rsvg_checker
// port-level checks of the ring sector vertex generator
// ----------------------------------------------------------------------------
module rsvg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               out_last,
	input logic signed [18:0] out_x
);

	// a stalled item stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output item dropped while stalled");

	// a stalled item keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_x) && $stable(out_last))
		else $error("output item changed while stalled");

	// an accepted request keeps the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken without going busy");

	// no new request while a pair other than the last is pending
	a_walk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("ready during a pair walk");

endmodule

bind ring_sector_vertex_generator rsvg_checker u_rsvg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (vin.valid),
	.in_ready  (vin.ready),
	.out_valid (vout.valid),
	.out_ready (vout.ready),
	.out_last  (vout.last_pair),
	.out_x     (vout.outer_x)
);

// ----- sim/ring_sector_vertex_generator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_sector_vertex_generator_tb
// drives progress angles into the ring sector generator and checks every
// vertex pair against a predictor kept inside the bench, with directed
// corner cases, random sector settings and random idling on both sides
// ----------------------------------------------------------------------------
module ring_sector_vertex_generator_tb;

	localparam longint CYCLE_LIMIT = 20000000;
	localparam int     STAGES      = 16;
	localparam longint ARC_TAB [STAGES] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861};

	typedef struct packed {
		logic signed [18:0] outer_x;
		logic signed [18:0] outer_y;
		logic signed [17:0] outer_u;
		logic signed [17:0] outer_v;
		logic signed [18:0] inner_x;
		logic signed [18:0] inner_y;
		logic signed [17:0] inner_u;
		logic signed [17:0] inner_v;
		logic               last_pair;
	} vertex_pair_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_wdata = '0;

	rsvg_in_if  vin();
	rsvg_out_if vout();

	ring_sector_vertex_generator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .vin(vin), .vout(vout));

	always #2 clk = ~clk;

	// bench copy of the sector registers
	logic [10:0]        m_outer_r;
	logic [10:0]        m_inner_r;
	logic signed [15:0] m_start;
	logic signed [15:0] m_end;
	logic [5:0]         m_div;
	logic               m_cw;

	vertex_pair_t pending_pairs[$];
	int  errors = 0;
	int  send_idle_pct = 0;   // chance in a hundred of a sender gap
	int  recv_stall_pct = 0;  // chance in a hundred of a receiver stall
	logic hold_on = 1'b0;     // long receiver hold-off in progress
	event hold_go;
	longint cycles = 0;

	function automatic longint rnd_sh(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	// round half away from zero
	function automatic longint div_away(longint n, longint d);
		bit neg;
		longint q;
		neg = (n < 0) ^ (d < 0);
		if (n < 0) n = -n;
		if (d < 0) d = -d;
		q = (n + d / 2) / d;
		return neg ? -q : q;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// angle num/den of a turn-in-64ths, reduced to a 32-bit binary angle
	function automatic longint angle_bam(longint num, longint den);
		longint r;
		r = num % den;
		if (r < 0) r += den;
		return (((r <<< 32) + den / 2) / den) & 64'hFFFF_FFFF;
	endfunction

	task automatic cordic_q15(input longint bam, output longint c, output longint s);
		longint z, x, y, dx, dy;
		bit flip;
		z = bam;
		x = rsvg_pkg::CORDIC_GAIN;
		y = 0;
		flip = 0;
		if (z >= (64'sd1 <<< 31)) z -= 64'sd1 <<< 32;
		if (z > (64'sd1 <<< 30)) begin
			z -= 64'sd1 <<< 31;
			flip = 1;
		end else if (z < -(64'sd1 <<< 30)) begin
			z += 64'sd1 <<< 31;
			flip = 1;
		end
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ARC_TAB[i];
			end else begin
				x += dx; y -= dy; z += ARC_TAB[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = clip(rnd_sh(x, 15), -32768, 32767);
		s = clip(rnd_sh(y, 15), -32768, 32767);
	endtask

	task automatic vertex_at(input longint num, input longint den, input longint f,
		input bit last, output vertex_pair_t vp);
		longint c, s, big_r, small_r, ctr, tc, ts;
		big_r = m_outer_r;
		small_r = m_inner_r;
		ctr = big_r * 16;
		tc = 0;
		ts = 0;
		cordic_q15(angle_bam(num, den), c, s);
		vp.outer_x = 19'(ctr + rnd_sh(big_r * f * c, 24));
		vp.outer_y = 19'(ctr - rnd_sh(big_r * f * s, 24));
		vp.outer_u = 18'(16384 + rnd_sh(f * c, 14));
		vp.outer_v = 18'(16384 - rnd_sh(f * s, 14));
		vp.inner_x = 19'(ctr + rnd_sh(small_r * c, 11));
		vp.inner_y = 19'(ctr - rnd_sh(small_r * s, 11));
		// radius zero leaves the inner texture term out
		if (big_r != 0) begin
			tc = div_away(small_r * c, 2 * big_r);
			ts = div_away(small_r * s, 2 * big_r);
		end
		vp.inner_u = 18'(clip(16384 + tc, -65536, 131071));
		vp.inner_v = 18'(clip(16384 - ts, -65536, 131071));
		vp.last_pair = last;
	endtask

	// expected strip for one progress angle: walk pairs then the final pair
	task automatic strip_for_angle(input logic signed [15:0] angle);
		longint st, en, span, dv, p, lo, hi, n, den, base, step, c, s, f;
		vertex_pair_t vp;
		st = m_start;
		en = m_end;
		span = en - st;
		dv = clip(m_div, 1, rsvg_pkg::MAX_DIVISIONS_DEF);
		lo = st < en ? st : en;
		hi = st < en ? en : st;
		p = clip(angle, lo, hi);
		den = rsvg_pkg::TURN_64 * dv;
		base = m_cw ? en : st;
		step = m_cw ? -span : span;
		n = 0;
		if (span != 0) n = clip((m_cw ? (en - p) : (p - st)) * dv / span, 0, dv);
		cordic_q15(angle_bam(span, 2 * den), c, s);
		// cosine of zero at the half step saturates the factor at +4
		if (c == 0) f = 32768;
		else f = clip(div_away(rsvg_pkg::F_NUM, c), -32768, 32768);
		for (longint i = 0; i <= n; i++) begin
			vertex_at(base * dv + i * step, den, f, 1'b0, vp);
			pending_pairs.push_back(vp);
		end
		vertex_at(p * dv, den, f, 1'b1, vp);
		pending_pairs.push_back(vp);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			rsvg_pkg::REG_OUTER_RADIUS: m_outer_r = data[10:0];
			rsvg_pkg::REG_INNER_RADIUS: m_inner_r = data[10:0];
			rsvg_pkg::REG_START_ANGLE:  m_start = data;
			rsvg_pkg::REG_END_ANGLE:    m_end = data;
			rsvg_pkg::REG_DIVISIONS:    m_div = data[5:0];
			rsvg_pkg::REG_CLOCKWISE:    m_cw = data[0];
			default: ;
		endcase
	endtask

	task automatic set_sector(input int ro, input int ri, input int st, input int en,
		input int dv, input bit cw);
		write_reg(rsvg_pkg::REG_OUTER_RADIUS, 16'(ro));
		write_reg(rsvg_pkg::REG_INNER_RADIUS, 16'(ri));
		write_reg(rsvg_pkg::REG_START_ANGLE, 16'(st));
		write_reg(rsvg_pkg::REG_END_ANGLE, 16'(en));
		write_reg(rsvg_pkg::REG_DIVISIONS, 16'(dv));
		write_reg(rsvg_pkg::REG_CLOCKWISE, 16'(cw));
	endtask

	// one item on the input channel; valid stays up into the next call
	task automatic send_angle(input logic signed [15:0] angle);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			vin.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		vin.valid <= 1'b1;
		vin.progress_angle <= angle;
		do @(posedge clk); while (!vin.ready);
		strip_for_angle(angle);
	endtask

	// drain: all pairs in, then a short settle before any register write
	task automatic wait_drained();
		vin.valid <= 1'b0;
		while (pending_pairs.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic check_field(input string name, input longint exp_v, input longint act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	// long receiver hold-off, counted here
	always begin
		@(hold_go);
		hold_on <= 1'b1;
		repeat (3000) @(posedge clk);
		hold_on <= 1'b0;
	end

	// receiver: checks each pair taken and picks ready for the next cycle
	always @(posedge clk) begin
		vertex_pair_t want;
		if (vout.valid && vout.ready) begin
			if (pending_pairs.size() == 0) begin
				errors++;
				$display("%0t unexpected pair x=%0d y=%0d", $time, vout.outer_x, vout.outer_y);
			end else begin
				want = pending_pairs.pop_front();
				check_field("outer_x", want.outer_x, vout.outer_x);
				check_field("outer_y", want.outer_y, vout.outer_y);
				check_field("outer_u", want.outer_u, vout.outer_u);
				check_field("outer_v", want.outer_v, vout.outer_v);
				check_field("inner_x", want.inner_x, vout.inner_x);
				check_field("inner_y", want.inner_y, vout.inner_y);
				check_field("inner_u", want.inner_u, vout.inner_u);
				check_field("inner_v", want.inner_v, vout.inner_v);
				check_field("last_pair", want.last_pair, vout.last_pair);
			end
		end
		if (hold_on)
			vout.ready <= 1'b0;
		else
			vout.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// defaults after reset, field extremes, clamping on both sides
	task automatic test_defaults();
		logic signed [15:0] pts [7] = '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd23040,
			-16'sd23040, 16'sd11520, 16'sd1};
		foreach (pts[i]) send_angle(pts[i]);
		wait_drained();
	endtask

	// widest radii, clockwise walk, full negative to positive span
	task automatic test_radius_and_direction();
		set_sector(2047, 2047, -23040, 23040, 3, 1);
		send_angle(16'sd0);
		send_angle(16'sd23040);
		send_angle(-16'sd100);
		wait_drained();
		set_sector(1, 0, 23040, -23040, 2, 0);   // reversed span, half step of 180
		send_angle(16'sd5000);
		send_angle(-16'sd32768);
		wait_drained();
	endtask

	// outer radius of zero and an empty span
	task automatic test_zero_cases();
		set_sector(0, 2047, 7000, 7000, 5, 0);
		send_angle(16'sd7000);
		send_angle(16'sd32767);
		wait_drained();
		write_reg(rsvg_pkg::REG_CLOCKWISE, 16'd1);
		send_angle(-16'sd32768);
		wait_drained();
	endtask

	// divisions of zero and beyond the maximum, plus two dropped indexes
	task automatic test_division_limits();
		set_sector(100, 50, 0, 1000, 0, 0);
		send_angle(16'sd600);
		wait_drained();
		write_reg(rsvg_pkg::REG_DIVISIONS, 16'd63);
		write_reg(3'd6, 16'hFFFF);
		write_reg(3'd7, 16'h0000);
		send_angle(16'sd777);
		wait_drained();
	endtask

	// a half step of 90 degrees gives a cosine of zero
	task automatic test_zero_cosine();
		set_sector(300, 20, 0, 11520, 1, 0);
		send_angle(16'sd11520);
		send_angle(16'sd4000);
		wait_drained();
	endtask

	// random sectors over the idling phases; large division counts are rare
	task automatic test_random_strips();
		int dv;
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct  = (phase == 1) ? 68 : (phase == 3) ? 18 : 0;
			recv_stall_pct = (phase == 2) ? 68 : (phase == 3) ? 18 : 0;
			for (int k = 0; k < 4; k++) begin
				dv = ($urandom_range(19) == 0) ? $urandom_range(63) : $urandom_range(1, 6);
				set_sector($urandom_range(2047), $urandom_range(2047),
					$urandom_range(46080) - 23040,
					($urandom_range(9) == 0) ? $urandom_range(65535)
						: $urandom_range(46080) - 23040,
					dv, $urandom_range(1));
				// long hold-off while items keep coming, so the input backs up
				if (phase == 0 && k == 1) -> hold_go;
				for (int j = 0; j < 16; j++) begin
					if ($urandom_range(7) == 0) send_angle(16'($urandom_range(65535)));
					else send_angle(16'($urandom_range(46080) - 23040));
				end
				wait_drained();
			end
		end
	endtask

	initial begin
		vin.valid = 1'b0;
		vin.progress_angle = '0;
		m_outer_r = 11'd100;
		m_inner_r = 11'd50;
		m_start = 16'sd0;
		m_end = 16'sd23040;
		m_div = 6'd8;
		m_cw = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_radius_and_direction();
		test_zero_cases();
		test_division_limits();
		test_zero_cosine();
		test_random_strips();
		if (errors == 0 && pending_pairs.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
